// ===== sv/cse_pkg.sv =====
// Package for the cosine similarity engine: shared types, widths and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cse_pkg;
  localparam int ElemBits  = 16;
  localparam int ProdBits  = 2 * ElemBits;
  localparam int AccBits   = 41;
  localparam int FracBits  = 15;
  localparam int RootBits  = (AccBits + 1) / 2;
  localparam int DenBits   = 2 * RootBits;
  localparam int NumBits   = AccBits + FracBits;
  localparam int QDepth    = 4;
  localparam int QPtrBits  = $clog2(QDepth);
  localparam int QCntBits  = QPtrBits + 1;

  typedef logic signed [AccBits-1:0] acc_t;

  typedef struct packed {
    acc_t dot;
    acc_t na;
    acc_t nb;
  } cse_sums_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } cse_state_e;

  function automatic acc_t sat_add(input acc_t s, input logic signed [ProdBits-1:0] p);
    logic signed [AccBits:0] r;
    r = {s[AccBits-1], s} + {{(AccBits + 1 - ProdBits){p[ProdBits-1]}}, p};
    if (r[AccBits] != r[AccBits-1]) begin
      return r[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
    end
    return r[AccBits-1:0];
  endfunction
endpackage

// ===== sv/cse_front.sv =====
// Front end: registers the element products and keeps the three saturating sums.
// On the last element it pushes the finished sums to the queue. Uses cse_pkg.
`timescale 1ns / 1ps
module cse_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [cse_pkg::ElemBits-1:0]   elem_a_i,
  input  logic signed [cse_pkg::ElemBits-1:0]   elem_b_i,
  input  logic                                  last_elem_i,
  input  logic [cse_pkg::QCntBits-1:0]          q_cnt_i,
  output logic                                  q_push_o,
  output cse_pkg::cse_sums_t                    q_data_o
);
  import cse_pkg::*;

  logic                        s1_v_q, s1_last_q;
  logic signed [ProdBits-1:0]  pab_q, paa_q, pbb_q;
  acc_t                        dot_q, na_q, nb_q;
  acc_t                        dot_d, na_d, nb_d;
  logic                        accept;
  logic [QCntBits:0]           used;

  // one transaction may still be in the product stage heading for the queue
  assign used   = {1'b0, q_cnt_i} + {{QCntBits{1'b0}}, s1_v_q & s1_last_q};
  assign full   = used >= (QCntBits + 1)'(QDepth);
  assign accept = push & ~full;

  assign dot_d = sat_add(dot_q, pab_q);
  assign na_d  = sat_add(na_q, paa_q);
  assign nb_d  = sat_add(nb_q, pbb_q);

  assign q_push_o = s1_v_q & s1_last_q;
  assign q_data_o = '{dot: dot_d, na: na_d, nb: nb_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      dot_q     <= '0;
      na_q      <= '0;
      nb_q      <= '0;
    end else begin
      s1_v_q    <= accept;
      s1_last_q <= last_elem_i;
      if (s1_v_q) begin
        if (s1_last_q) begin
          dot_q <= '0;
          na_q  <= '0;
          nb_q  <= '0;
        end else begin
          dot_q <= dot_d;
          na_q  <= na_d;
          nb_q  <= nb_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pab_q <= elem_a_i * elem_b_i;
      paa_q <= elem_a_i * elem_a_i;
      pbb_q <= elem_b_i * elem_b_i;
    end
  end
endmodule

// ===== sv/cse_queue.sv =====
// Short queue of finished sums between the front end and the back end.
// Uses cse_pkg.
`timescale 1ns / 1ps
module cse_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  cse_pkg::cse_sums_t            data_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output cse_pkg::cse_sums_t            data_o,
  output logic [cse_pkg::QCntBits-1:0]  cnt_o
);
  import cse_pkg::*;

  cse_sums_t             mem_q [QDepth];
  logic [QPtrBits-1:0]   wr_q, rd_q;
  logic [QCntBits-1:0]   cnt_q;
  logic                  do_pop;

  assign empty_o = cnt_q == '0;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntBits'(push_i) - QCntBits'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

// ===== sv/cse_back.sv =====
// Back end: two digit-by-digit square roots, one product, a bit-serial divide
// and the result register. Uses cse_pkg.
`timescale 1ns / 1ps
module cse_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  input  cse_pkg::cse_sums_t                  q_data_i,
  output logic                                q_pop_o,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [cse_pkg::ElemBits-1:0] similarity_o,
  output logic                                zero_norm_o
);
  import cse_pkg::*;

  localparam int RemBits = RootBits + 3;
  localparam int XBits   = 2 * RootBits;

  cse_state_e state_q, state_d;
  logic [5:0] cnt_q;
  logic       neg_q, zero_q;
  logic [XBits-1:0]    xa_q, xb_q;
  logic [RemBits-1:0]  ra_rem_q, rb_rem_q;
  logic [RootBits-1:0] ra_q, rb_q;
  logic [DenBits-1:0]  den_q;
  logic [NumBits-1:0]  dvd_q;
  logic [DenBits-1:0]  rem_q;
  logic                out_v_q;
  logic                start, zero_in, out_free, load_out;
  logic                last_step;

  logic [RemBits-1:0]  ta_rem, tb_rem, ta_try, tb_try;
  logic [DenBits-1:0]  rem_sh;
  logic [AccBits-1:0]  dot_mag;
  logic signed [ElemBits-1:0] q_sat;

  assign zero_in  = (q_data_i.na <= 0) || (q_data_i.nb <= 0);
  assign out_free = ~out_v_q | pop;
  assign empty    = ~out_v_q;
  assign last_step = (state_q == ST_SQRT) ? (cnt_q == 6'(RootBits - 1))
                                          : (cnt_q == 6'(NumBits - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = zero_in ? ST_DONE : ST_SQRT;
      ST_SQRT: if (last_step) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (last_step) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: start    = ~q_empty_i;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end
  assign q_pop_o = start;

  // one root digit per cycle on each norm
  assign ta_rem = {ra_rem_q[RemBits-3:0], xa_q[XBits-1 -: 2]};
  assign tb_rem = {rb_rem_q[RemBits-3:0], xb_q[XBits-1 -: 2]};
  assign ta_try = {1'b0, ra_q, 2'b01};
  assign tb_try = {1'b0, rb_q, 2'b01};

  assign rem_sh = {rem_q[DenBits-2:0], dvd_q[NumBits-1]};

  assign q_sat = neg_q ? ((dvd_q > NumBits'(32768)) ? ElemBits'(-32768)
                                                    : -dvd_q[ElemBits-1:0])
                       : ((dvd_q > NumBits'(32767)) ? ElemBits'(32767)
                                                    : dvd_q[ElemBits-1:0]);

  always_comb begin
    dot_mag = q_data_i.dot[AccBits-1] ? AccBits'(-q_data_i.dot) : q_data_i.dot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start || (state_q == ST_MUL) || last_step) cnt_q <= '0;
      else cnt_q <= cnt_q + 1'b1;
      if (load_out) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      zero_q   <= zero_in;
      neg_q    <= q_data_i.dot[AccBits-1];
      xa_q     <= XBits'(q_data_i.na);
      xb_q     <= XBits'(q_data_i.nb);
      ra_rem_q <= '0;
      rb_rem_q <= '0;
      ra_q     <= '0;
      rb_q     <= '0;
      dvd_q    <= {dot_mag, {FracBits{1'b0}}};
      rem_q    <= '0;
    end
    if (state_q == ST_SQRT) begin
      xa_q <= {xa_q[XBits-3:0], 2'b00};
      xb_q <= {xb_q[XBits-3:0], 2'b00};
      if (ta_rem >= ta_try) begin
        ra_rem_q <= ta_rem - ta_try;
        ra_q     <= {ra_q[RootBits-2:0], 1'b1};
      end else begin
        ra_rem_q <= ta_rem;
        ra_q     <= {ra_q[RootBits-2:0], 1'b0};
      end
      if (tb_rem >= tb_try) begin
        rb_rem_q <= tb_rem - tb_try;
        rb_q     <= {rb_q[RootBits-2:0], 1'b1};
      end else begin
        rb_rem_q <= tb_rem;
        rb_q     <= {rb_q[RootBits-2:0], 1'b0};
      end
    end
    if (state_q == ST_MUL) den_q <= ra_q * rb_q;
    if (state_q == ST_DIV) begin
      if (rem_sh >= den_q) begin
        rem_q <= rem_sh - den_q;
        dvd_q <= {dvd_q[NumBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        dvd_q <= {dvd_q[NumBits-2:0], 1'b0};
      end
    end
    if (load_out) begin
      similarity_o <= zero_q ? '0 : q_sat;
      zero_norm_o  <= zero_q;
    end
  end
endmodule

// ===== sv/cosine_similarity_engine_top.sv =====
// Top level of the cosine similarity engine.
// Instantiates cse_front, cse_queue and cse_back; uses cse_pkg.
//
// Usage:
//   Input queue side: drive elem_a_i, elem_b_i, last_elem_i with push; a
//   transaction is taken on a clock edge with push high and full low. Element
//   pairs stream at one per cycle while full is low. last_elem_i closes a vector pair.
//   Result queue side: while empty is low, similarity_o (Q1.15) and
//   zero_norm_o hold the oldest result; pop with empty low takes it.
//   A result passes, after its last element, through the product and sum
//   register, the queue read, 21 root steps, one multiply, 56 divide steps
//   and the result load. A vector whose norm is zero skips the arithmetic.
//   The back end works on one vector at a time and takes the next only
//   after loading its result. Up to four finished vectors wait between
//   front and back; full rises when queued plus in-flight vectors reach four.
//   When the receiver stalls, the result holds, the back end stops, the queue
//   fills and then full stops the input.
//   Reset clears the running sums, the queue and the result valid flag.
`timescale 1ns / 1ps
module cosine_similarity_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [cse_pkg::ElemBits-1:0] elem_a_i,
  input  logic signed [cse_pkg::ElemBits-1:0] elem_b_i,
  input  logic                                last_elem_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [cse_pkg::ElemBits-1:0] similarity_o,
  output logic                                zero_norm_o
);
  import cse_pkg::*;

  logic                 q_push, q_pop, q_empty;
  cse_sums_t            q_wdata, q_rdata;
  logic [QCntBits-1:0]  q_cnt;

  cse_front u_front (
    .clk_i, .rst_ni, .push, .full, .elem_a_i, .elem_b_i, .last_elem_i,
    .q_cnt_i(q_cnt), .q_push_o(q_push), .q_data_o(q_wdata)
  );

  cse_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_wdata), .pop_i(q_pop),
    .empty_o(q_empty), .data_o(q_rdata), .cnt_o(q_cnt)
  );

  cse_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_rdata), .q_pop_o(q_pop),
    .empty, .pop, .similarity_o, .zero_norm_o
  );
endmodule

// ===== tb/cse_checker.sv =====
// Checker for the cosine similarity engine: watches both queue sides,
// predicts each result from the accepted element pairs and compares. Uses cse_pkg.
`timescale 1ns / 1ps
module cse_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  logic                                full,
  input  logic signed [cse_pkg::ElemBits-1:0] elem_a_i,
  input  logic signed [cse_pkg::ElemBits-1:0] elem_b_i,
  input  logic                                last_elem_i,
  input  logic                                empty,
  input  logic                                pop,
  input  logic signed [cse_pkg::ElemBits-1:0] similarity_o,
  input  logic                                zero_norm_o,
  output int                                  fail_count,
  output int                                  pending_count
);
  import cse_pkg::*;

  typedef struct packed {
    logic signed [15:0] sim;
    logic               zero;
  } sim_result_t;

  localparam longint SumMax = (64'sd1 <<< 40) - 1;
  localparam longint SumMin = -(64'sd1 <<< 40);

  longint dot_acc, na_acc, nb_acc;
  sim_result_t sim_q[$];

  function automatic longint clamp_sum(input longint s, input longint p);
    longint r;
    r = s + p;
    if (r > SumMax) return SumMax;
    if (r < SumMin) return SumMin;
    return r;
  endfunction

  function automatic longint floor_root(input longint x);
    longint r;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= x) r = r + (64'sd1 <<< b);
    end
    return r;
  endfunction

  function automatic sim_result_t similarity_of(input longint d, input longint na,
                                                input longint nb);
    sim_result_t res;
    longint q;
    res.zero = (na <= 0) || (nb <= 0);
    if (res.zero) q = 0;
    else begin
      q = (d * 32768) / (floor_root(na) * floor_root(nb));
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end
    res.sim = q[15:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint a, b;
    sim_result_t exp_r;
    if (!rst_ni) begin
      dot_acc <= 0;
      na_acc <= 0;
      nb_acc <= 0;
      fail_count <= 0;
      pending_count <= 0;
      sim_q.delete();
    end else begin
      if (pop && !empty) begin
        if (sim_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t unexpected result sim=%0d zero=%0b", $realtime, similarity_o,
                     zero_norm_o);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = sim_q.pop_front();
          if (exp_r.sim !== similarity_o || exp_r.zero !== zero_norm_o) begin
            if (fail_count < 10)
              $display("%0t mismatch: exp sim=%0d zero=%0b got sim=%0d zero=%0b",
                       $realtime, exp_r.sim, exp_r.zero, similarity_o, zero_norm_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) begin
        a = elem_a_i;
        b = elem_b_i;
        if (last_elem_i) begin
          sim_q.insert(sim_q.size(),
                       similarity_of(clamp_sum(dot_acc, a * b), clamp_sum(na_acc, a * a),
                                     clamp_sum(nb_acc, b * b)));
          dot_acc <= 0;
          na_acc <= 0;
          nb_acc <= 0;
        end else begin
          dot_acc <= clamp_sum(dot_acc, a * b);
          na_acc <= clamp_sum(na_acc, a * a);
          nb_acc <= clamp_sum(nb_acc, b * b);
        end
      end
      pending_count <= sim_q.size();
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the cosine similarity engine: clock, reset, element
// stimulus and result popping. Depends on cse_checker, the block and cse_pkg.
`timescale 1ns / 1ps
module tb;
  import cse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [15:0] elem_a_i = '0;
  logic signed [15:0] elem_b_i = '0;
  logic last_elem_i = 1'b0;
  logic full, empty, zero_norm_o;
  logic signed [15:0] similarity_o;
  int fail_count, pending_count;
  logic hold_go = 1'b0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  always #4 clk_i = ~clk_i;

  cosine_similarity_engine_top dut (.*);
  cse_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off once asked
  always @(negedge clk_i) begin
    if (hold_go && hold_cycles < 1500) begin
      hold_cycles <= hold_cycles + 1;
      pop <= 1'b0;
    end else pop <= ($urandom_range(0, 9) < 7);
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic lst);
    elem_a_i <= a;
    elem_b_i <= b;
    last_elem_i <= lst;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    push <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_elem(input int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(input int len, input int mode);
    logic [15:0] a, b;
    for (int i = 0; i < len; i++) begin
      a = rand_elem(mode == 1 ? $urandom_range(0, 9) : 3);
      b = (mode == 2) ? a : (mode == 3 ? -a : rand_elem($urandom_range(0, 12)));
      if (mode == 4) b = 16'h0;
      send_pair(a, b, i == len - 1);
      if ($urandom_range(0, 7) == 0) pause_sender();
    end
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, zero norms, parallel and opposite, single elements
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h7fff, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h7fff, 16'h7fff, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h0003, 16'h0002, 1'b0);
    send_pair(16'h0001, 16'h0005, 1'b1);
    send_pair(16'hffff, 16'h0001, 1'b1);
    send_pair(16'h5555, 16'haaaa, 1'b1);
    push <= 1'b0;
    // saturate the sums: 1040 items of full-scale values
    for (int i = 0; i < 1040; i++) send_pair(16'h8000, 16'h7fff, i == 1039);
    // long receiver hold-off while sending short vectors
    hold_go = 1'b1;
    sent = 0;
    repeat (40) send_vector($urandom_range(1, 3), $urandom_range(0, 4));
    push <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk_i);
    sent = 0;
    while (sent < 100) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_vector(len, $urandom_range(0, 6));
      sent += len;
      if ($urandom_range(0, 3) == 0) pause_sender();
    end
    push <= 1'b0;
    wait (pending_count == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && !(!empty)) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
